// File: rtl/utf8fs_pkg.sv
// Shared types, constants and byte classification for the UTF-8 filename sanitizer.
`default_nettype none

package utf8fs_pkg;

  localparam logic [15:0] BUF_SIZE_RESET = 16'd256;
  localparam int unsigned MAX_BURST      = 4;
  localparam int unsigned HELD_DEPTH     = 3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // One burst of results produced by one input word.
  typedef struct packed {
    logic [15:0]                     base;
    logic [MAX_BURST-1:0][7:0]       bytes;
    logic [1:0]                      last_idx;
    logic                            is_final;
    logic [15:0]                     final_len;
  } burst_t;

  // Sequence length of a lead byte; 0 for continuation or invalid bytes.
  function automatic logic [2:0] seq_length(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b[7] == 1'b0) begin
      n = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      n = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Control bytes and the nine characters not allowed in a filename.
  function automatic logic is_forbidden(input logic [7:0] b);
    return (b < CHAR_SPACE) ||
           (b inside {8'h2F, 8'h5C, 8'h3A, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E, 8'h7C});
  endfunction

  function automatic logic is_continuation(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8fs_core.sv
// Decode step: string state registers and the per-word burst computation.
`default_nettype none

module utf8fs_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 go,
  input  wire logic [7:0]           byte_in,
  input  wire logic [15:0]          buffer_size,
  output      logic                 emit,
  output      utf8fs_pkg::burst_t   burst
);

  logic [utf8fs_pkg::HELD_DEPTH-1:0][7:0] held_r, held_nxt;
  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [15:0] wp_r, wp_nxt;
  logic [15:0] kept_r, kept_nxt;
  logic        stopped_r, stopped_nxt;

  logic [2:0]  seq_n;
  logic [2:0]  total;
  logic        fits_total;
  logic        fits_one;
  logic [16:0] need_total;
  logic [16:0] need_one;

  assign seq_n      = utf8fs_pkg::seq_length(byte_in);
  assign total      = {1'b0, count_r} + 3'd1;
  assign need_total = {1'b0, wp_r} + {14'd0, total} + 17'd1;
  assign need_one   = {1'b0, wp_r} + 17'd2;
  assign fits_total = need_total <= {1'b0, buffer_size};
  assign fits_one   = need_one <= {1'b0, buffer_size};

  always_comb begin
    held_nxt    = held_r;
    needed_nxt  = needed_r;
    count_nxt   = count_r;
    wp_nxt      = wp_r;
    kept_nxt    = kept_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;

    burst           = '0;
    burst.base      = wp_r;
    burst.bytes[0]  = held_r[0];
    burst.bytes[1]  = held_r[1];
    burst.bytes[2]  = held_r[2];
    burst.bytes[3]  = byte_in;

    if (go) begin
      if (byte_in == 8'd0) begin
        // terminator: report trimmed length, restart the string
        emit            = 1'b1;
        burst           = '0;
        burst.is_final  = 1'b1;
        burst.final_len = kept_r;
        needed_nxt      = 2'd0;
        count_nxt       = 2'd0;
        wp_nxt          = 16'd0;
        kept_nxt        = 16'd0;
        stopped_nxt     = 1'b0;
      end else if (stopped_r) begin
        // drop everything until the terminator
      end else if (needed_r != 2'd0) begin
        if (!utf8fs_pkg::is_continuation(byte_in)) begin
          stopped_nxt = 1'b1;
          needed_nxt  = 2'd0;
          count_nxt   = 2'd0;
        end else if (needed_r > 2'd1) begin
          case (count_r)
            2'd0:    held_nxt[0] = byte_in;
            2'd1:    held_nxt[1] = byte_in;
            2'd2:    held_nxt[2] = byte_in;
            default: ;
          endcase
          count_nxt  = count_r + 2'd1;
          needed_nxt = needed_r - 2'd1;
        end else begin
          needed_nxt = 2'd0;
          count_nxt  = 2'd0;
          if (!fits_total) begin
            stopped_nxt = 1'b1;
          end else begin
            emit           = 1'b1;
            burst.last_idx = count_r;
            case (count_r)
              2'd0:    burst.bytes[0] = byte_in;
              2'd1:    burst.bytes[1] = byte_in;
              2'd2:    burst.bytes[2] = byte_in;
              default: burst.bytes[3] = byte_in;
            endcase
            wp_nxt   = wp_r + {13'd0, total};
            kept_nxt = wp_r + {13'd0, total};
          end
        end
      end else begin
        if (seq_n == 3'd1) begin
          if (!utf8fs_pkg::is_forbidden(byte_in)) begin
            if (!fits_one) begin
              stopped_nxt = 1'b1;
            end else begin
              emit           = 1'b1;
              burst.last_idx = 2'd0;
              burst.bytes[0] = byte_in;
              wp_nxt         = wp_r + 16'd1;
              if (byte_in != utf8fs_pkg::CHAR_SPACE && byte_in != utf8fs_pkg::CHAR_DOT) begin
                kept_nxt = wp_r + 16'd1;
              end
            end
          end
        end else if (seq_n != 3'd0) begin
          // lead byte of a multi-byte sequence: hold it
          held_nxt[0] = byte_in;
          count_nxt   = 2'd1;
          needed_nxt  = 2'(seq_n - 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (!rst_n) begin
      needed_r  <= 2'd0;
      count_r   <= 2'd0;
      wp_r      <= 16'd0;
      kept_r    <= 16'd0;
      stopped_r <= 1'b0;
    end else begin
      needed_r  <= needed_nxt;
      count_r   <= count_nxt;
      wp_r      <= wp_nxt;
      kept_r    <= kept_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (needed_r == 2'd0) |-> (count_r == 2'd0))
    else $error("held count nonzero with no sequence pending");

  a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (needed_r != 2'd0) |-> ({1'b0, needed_r} + {1'b0, count_r} <= 3'd4 && count_r != 2'd0))
    else $error("pending sequence longer than four bytes");

  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && go && byte_in != 8'd0) |-> !emit)
    else $error("output after stop");

  a_kept_le_wp: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= wp_r)
    else $error("trimmed length beyond write position");

endmodule

`default_nettype wire

// File: rtl/utf8fs_burst.sv
// Result buffer: holds one burst and plays it out one word per handshake.
`default_nettype none

module utf8fs_burst (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire utf8fs_pkg::burst_t  burst_in,
  output      logic                can_load,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [15:0]         out_write_addr,
  output      logic [7:0]          out_write_byte,
  output      logic                out_is_final,
  output      logic [15:0]         out_final_length,
  output      logic                out_last
);

  utf8fs_pkg::burst_t burst_r;
  logic               busy_r, busy_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               take;
  logic               done;

  assign take     = busy_r && !out_stall;
  assign done     = take && (idx_r == burst_r.last_idx);
  assign can_load = !busy_r || done;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst_in;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign out_valid        = busy_r;
  assign out_write_addr   = burst_r.is_final ? 16'd0 : burst_r.base + {14'd0, idx_r};
  assign out_write_byte   = burst_r.is_final ? 8'd0 : burst_r.bytes[idx_r];
  assign out_is_final     = burst_r.is_final;
  assign out_final_length = burst_r.is_final ? burst_r.final_len : 16'd0;
  assign out_last         = idx_r == burst_r.last_idx;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= burst_r.last_idx))
    else $error("burst index past last result");

  a_final_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && burst_r.is_final) |-> (burst_r.last_idx == 2'd0))
    else $error("final result inside a multi-word burst");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("burst loaded over unfinished burst");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_stall && !load) |=> (busy_r && $stable(idx_r)))
    else $error("burst advanced while stalled");

endmodule

`default_nettype wire

// File: rtl/utf8_filename_sanitiser_unit.sv
// Top level of the UTF-8 filename sanitizer: input register, size register, decode, result buffer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | input     | in_valid / in_stall  | in_byte
//   out     | output    | out_valid / out_stall| out_write_addr, out_write_byte, out_is_final,
//           |           |                      | out_final_length, out_last
//   cfg     | input     | cfg_we               | cfg_wdata (buffer_size)
//
// An accepted word is held in the input register, is decoded in a single pass and lands in
// the result buffer, which presents its first result.
// One word per cycle is taken while out_stall is low and every word yields at most one result;
// a word with several results holds the result buffer and the input until its last one is taken.
// rst_n (synchronous) clears the string state and sets buffer_size to 256.
// out_stall holds the current result and backs up into in_stall through the input register.
`default_nettype none

module utf8_filename_sanitiser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [15:0] out_write_addr,
  output      logic [7:0]  out_write_byte,
  output      logic        out_is_final,
  output      logic [15:0] out_final_length,
  output      logic        out_last,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic               in_v_r, in_v_nxt;
  logic [7:0]         in_byte_r;
  logic [15:0]        buf_size_r, buf_size_nxt;
  logic               can_load;
  logic               advance;
  logic               emit;
  utf8fs_pkg::burst_t burst;

  // advance the held word into decode once the result buffer can take its burst
  assign advance  = in_v_r && can_load;
  assign in_stall = in_v_r && !can_load;

  always_comb begin
    in_v_nxt = in_v_r;
    if (!in_stall) begin
      in_v_nxt = in_valid;
    end
    buf_size_nxt = cfg_we ? cfg_wdata : buf_size_r;
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_byte;
    end
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      buf_size_r <= utf8fs_pkg::BUF_SIZE_RESET;
    end else begin
      in_v_r     <= in_v_nxt;
      buf_size_r <= buf_size_nxt;
    end
  end

  utf8fs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (advance),
    .byte_in     (in_byte_r),
    .buffer_size (buf_size_r),
    .emit        (emit),
    .burst       (burst)
  );

  utf8fs_burst u_burst (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && emit),
    .burst_in         (burst),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_addr   (out_write_addr),
    .out_write_byte   (out_write_byte),
    .out_is_final     (out_is_final),
    .out_final_length (out_final_length),
    .out_last         (out_last)
  );

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (in_v_r && $stable(in_byte_r)))
    else $error("held input word lost under stall");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_final) |-> out_last)
    else $error("final result not marked last");

  a_advance_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> advance)
    else $error("burst produced without a word");

endmodule

`default_nettype wire

// File: sim/utf8_filename_sanitiser_unit_tb.sv
// Self-checking testbench for the UTF-8 filename sanitizer: predicts buffer writes per word.
`default_nettype none

module utf8_filename_sanitiser_unit_tb;

  localparam int unsigned STALL_LIMIT    = 3000;  // cycles with no handshake before giving up
  localparam int unsigned SETTLE_CYCLES  = 8;     // covers the trip through the input register plus a burst
  localparam int unsigned SQUEEZE_CYCLES = 80;    // long receiver hold-off
  localparam int unsigned SQUEEZE_EVERY  = 45;    // input words between hold-offs
  localparam int unsigned PHASE_BYTES    = 10;    // minimum random words per buffer size
  localparam int unsigned MAX_REPORTS    = 10;
  localparam string       BANNED_CHARS   = "/\\:*?\"<>|";
  localparam logic [7:0]  TERMINATOR     = 8'h00;

  // Directed strings: every byte class, a complete string with trailing space and dot,
  // a terminator in the middle of a sequence, and a malformed continuation.
  localparam logic [7:0] DIRECTED [25] = '{
    8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
    8'h2F, 8'h01, 8'h80, 8'hFF, 8'h20, 8'h2E, 8'h00,
    8'hE2, 8'h82, 8'h00,
    8'hC3, 8'h41, 8'h42, 8'h00
  };

  // Buffer sizes walked through after the directed part; zero and all ones are the extremes.
  localparam logic [15:0] SIZES [7] = '{
    16'd0, 16'd1, 16'd3, 16'd6, 16'hFFFF, 16'd12, utf8fs_pkg::BUF_SIZE_RESET
  };

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fin;
    logic [15:0] len;
    logic        last;
  } buf_write_t;

  typedef enum {
    K_TEXT, K_TRIM, K_MULTI, K_BANNED, K_CONTROL, K_STRAY, K_BAD_LEAD, K_BROKEN, K_CUT, K_NOISE
  } glyph_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_write_addr;
  logic [7:0]  out_write_byte;
  logic        out_is_final;
  logic [15:0] out_final_length;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  utf8_filename_sanitiser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_addr   (out_write_addr),
    .out_write_byte   (out_write_byte),
    .out_is_final     (out_is_final),
    .out_final_length (out_final_length),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sanitizer state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [15:0] buf_size;
  logic [7:0]  held_seq [3];
  int unsigned seq_missing;   // continuation bytes still owed (0 = no sequence open)
  int unsigned seq_held;      // bytes of the open sequence kept so far
  logic [15:0] next_addr;
  logic [15:0] trimmed_len;
  bit          halted;        // output blocked until the terminator

  buf_write_t  pending_writes [$];   // buffer writes predicted but not yet seen
  logic [7:0]  bytes_to_send [$];    // words waiting for the driver

  int unsigned words_in      = 0;
  int unsigned writes_seen   = 0;
  int unsigned strings_ended = 0;
  int unsigned squeezes      = 0;
  int unsigned mismatches    = 0;
  bit          in_fire       = 1'b0;

  function automatic bit is_banned(input logic [7:0] b);
    bit hit;
    hit = (b < utf8fs_pkg::CHAR_SPACE);
    for (int i = 0; i < BANNED_CHARS.len(); i++) begin
      if (b == BANNED_CHARS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Bytes in the character that a lead byte opens; 0 for continuation or invalid leads.
  function automatic int unsigned lead_len(input logic [7:0] b);
    if (!b[7]) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // The character must fit together with the terminating zero.
  function automatic bit room_for(input int unsigned n);
    return (32'(next_addr) + n + 1) <= 32'(buf_size);
  endfunction

  function automatic void clear_string();
    seq_missing = 0;
    seq_held    = 0;
    next_addr   = '0;
    trimmed_len = '0;
    halted      = 1'b0;
  endfunction

  function automatic void add_write(input logic [15:0] addr, input logic [7:0] data,
                                    input logic fin, input logic [15:0] len,
                                    input logic last);
    buf_write_t w;
    w.addr = addr;
    w.data = data;
    w.fin  = fin;
    w.len  = len;
    w.last = last;
    pending_writes.push_back(w);
  endfunction

  // Work out the buffer writes one accepted word causes and advance the state.
  function automatic void sanitize_byte(input logic [7:0] b);
    int unsigned total;
    int unsigned n;
    if (b == TERMINATOR) begin
      add_write('0, '0, 1'b1, trimmed_len, 1'b1);
      clear_string();
      return;
    end
    if (halted) return;

    if (seq_missing != 0) begin
      // A non-continuation inside a sequence kills the rest of the string.
      if (b[7:6] != 2'b10) begin
        halted      = 1'b1;
        seq_missing = 0;
        seq_held    = 0;
        return;
      end
      if (seq_missing > 1) begin
        if (seq_held < utf8fs_pkg::HELD_DEPTH) held_seq[seq_held] = b;
        seq_held++;
        seq_missing--;
        return;
      end
      total       = seq_held + 1;
      seq_missing = 0;
      seq_held    = 0;
      if (total > utf8fs_pkg::MAX_BURST || !room_for(total)) begin
        halted = 1'b1;
        return;
      end
      for (int k = 0; k + 1 < total; k++) begin
        add_write(next_addr + 16'(k), held_seq[k], 1'b0, '0, 1'b0);
      end
      add_write(next_addr + 16'(total - 1), b, 1'b0, '0, 1'b1);
      next_addr   = next_addr + 16'(total);
      trimmed_len = next_addr;
      return;
    end

    n = lead_len(b);
    if (n == 0) return;
    if (n == 1) begin
      if (is_banned(b)) return;
      if (!room_for(1)) begin
        halted = 1'b1;
        return;
      end
      add_write(next_addr, b, 1'b0, '0, 1'b1);
      next_addr = next_addr + 16'd1;
      if (b != utf8fs_pkg::CHAR_SPACE && b != utf8fs_pkg::CHAR_DOT) trimmed_len = next_addr;
      return;
    end
    held_seq[0] = b;
    seq_held    = 1;
    seq_missing = n - 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  function automatic logic [7:0] rand_lead(input int unsigned n);
    case (n)
      2:       return 8'hC0 | 8'($urandom_range(31));
      3:       return 8'hE0 | 8'($urandom_range(15));
      default: return 8'hF0 | 8'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Mostly well-formed characters; the rest is noise and broken sequences.
  function automatic glyph_kind_t draw_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return K_TEXT;
    if (r < 45) return K_TRIM;
    if (r < 68) return K_MULTI;
    if (r < 73) return K_BANNED;
    if (r < 77) return K_CONTROL;
    if (r < 81) return K_STRAY;
    if (r < 84) return K_BAD_LEAD;
    if (r < 89) return K_BROKEN;
    if (r < 92) return K_CUT;
    return K_NOISE;
  endfunction

  function automatic void queue_glyph(input glyph_kind_t kind);
    logic [7:0]  b;
    int unsigned n;
    case (kind)
      K_TEXT: begin
        do b = 8'($urandom_range(127, 33));
        while (is_banned(b) || b == utf8fs_pkg::CHAR_DOT);
        bytes_to_send.push_back(b);
      end
      K_TRIM: begin
        bytes_to_send.push_back($urandom_range(1) ? utf8fs_pkg::CHAR_SPACE
                                                  : utf8fs_pkg::CHAR_DOT);
      end
      K_MULTI: begin
        n = $urandom_range(4, 2);
        bytes_to_send.push_back(rand_lead(n));
        repeat (n - 1) bytes_to_send.push_back(rand_cont());
      end
      K_BANNED: begin
        bytes_to_send.push_back(BANNED_CHARS[$urandom_range(BANNED_CHARS.len() - 1)]);
      end
      K_CONTROL: begin
        bytes_to_send.push_back(8'($urandom_range(31, 1)));
      end
      K_STRAY: begin
        bytes_to_send.push_back(rand_cont());
      end
      K_BAD_LEAD: begin
        bytes_to_send.push_back(8'($urandom_range(255, 248)));
      end
      K_BROKEN: begin
        n = $urandom_range(4, 2);
        bytes_to_send.push_back(rand_lead(n));
        repeat ($urandom_range(n - 2)) bytes_to_send.push_back(rand_cont());
        do b = 8'($urandom_range(255, 1)); while (b[7:6] == 2'b10);
        bytes_to_send.push_back(b);
      end
      K_CUT: begin
        // Leave the sequence open; the caller ends the string right here.
        n = $urandom_range(4, 2);
        bytes_to_send.push_back(rand_lead(n));
        repeat ($urandom_range(n - 2)) bytes_to_send.push_back(rand_cont());
      end
      default: begin
        bytes_to_send.push_back(8'($urandom_range(255, 1)));
      end
    endcase
  endfunction

  function automatic void queue_random_string();
    int unsigned chars;
    glyph_kind_t kind;
    chars = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8);
    for (int i = 0; i < chars; i++) begin
      kind = draw_kind();
      queue_glyph(kind);
      if (kind == K_CUT) break;
    end
    bytes_to_send.push_back(TERMINATOR);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, hold a word until it is taken
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      // hold the word; the block has not taken it yet
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (bytes_to_send.size() != 0) begin
      in_byte  <= bytes_to_send.pop_front();
      in_valid <= 1'b1;
      // Flip now and then into a stretch of back-to-back words.
      if ($urandom_range(29) == 0) send_calm = !send_calm;
      send_gap = send_calm ? 0 : draw_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off every so many input words so
  // that the block fills up and pushes back on its input
  // ---------------------------------------------------------------------------
  int unsigned recv_gap     = 0;
  int unsigned squeeze_left = 0;
  int unsigned next_squeeze = 35;
  bit          recv_calm    = 1'b0;

  always @(negedge clk) begin
    if (squeeze_left != 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else if (words_in >= next_squeeze) begin
      next_squeeze += SQUEEZE_EVERY;
      squeeze_left = SQUEEZE_CYCLES - 1;
      squeezes++;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(29) == 0) recv_calm = !recv_calm;
      recv_gap = recv_calm ? 0 : draw_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge
  // ---------------------------------------------------------------------------
  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic void check_write();
    buf_write_t want;
    if (pending_writes.size() == 0) begin
      note_failure($sformatf("unexpected write addr=%0d byte=%02h final=%0b len=%0d last=%0b",
                             out_write_addr, out_write_byte, out_is_final,
                             out_final_length, out_last));
      return;
    end
    want = pending_writes.pop_front();
    if (want.addr !== out_write_addr || want.data !== out_write_byte ||
        want.fin !== out_is_final || want.len !== out_final_length ||
        want.last !== out_last) begin
      note_failure($sformatf({"expected addr=%0d byte=%02h final=%0b len=%0d last=%0b, ",
                              "got addr=%0d byte=%02h final=%0b len=%0d last=%0b"},
                             want.addr, want.data, want.fin, want.len, want.last,
                             out_write_addr, out_write_byte, out_is_final,
                             out_final_length, out_last));
    end
  endfunction

  always @(posedge clk) begin
    in_fire = rst_n && in_valid && !in_stall;
    if (in_fire) begin
      sanitize_byte(in_byte);
      words_in++;
    end
    if (rst_n && out_valid && !out_stall) begin
      writes_seen++;
      if (out_is_final === 1'b1) strings_ended++;
      check_write();
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles, %0d writes still expected",
               STALL_LIMIT, pending_writes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // Wait until every word is taken and every write has come out, then let any
  // word that causes no write work its way through.
  task automatic settle();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_valid || pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] size);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we    <= 1'b0;
    buf_size  = size;  // took effect at the rising edge just passed
  endtask

  initial begin
    buf_size = utf8fs_pkg::BUF_SIZE_RESET;
    clear_string();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings run at the reset buffer size.
    foreach (DIRECTED[i]) bytes_to_send.push_back(DIRECTED[i]);
    settle();

    foreach (SIZES[i]) begin
      write_buffer_size(SIZES[i]);
      while (bytes_to_send.size() < PHASE_BYTES) queue_random_string();
      settle();
    end

    $display("Sent %0d input words over %0d buffer sizes; checked %0d results,",
             words_in, $size(SIZES) + 1, writes_seen);
    $display("%0d of them string ends. Receiver held off %0d times for %0d cycles each.",
             strings_ended, squeezes, SQUEEZE_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
